// ===== rtl/register_field_decoder_top_assert.svh =====
// ---------------------------------------------------------------------------
// Register field decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef REGISTER_FIELD_DECODER_TOP_ASSERT_SVH
`define REGISTER_FIELD_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define RFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("register field decoder assertion failed");

// next-cycle implication
`define RFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("register field decoder assertion failed");

`endif

// ===== rtl/rfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Register field decoder package
// Widths, codes and payload types shared by the decoder modules.
// ---------------------------------------------------------------------------
package rfd_pkg;

  localparam int CountBits = 32;   // wrap counter width, 8..48
  localparam int RawW      = 64;
  localparam int FieldW    = 63;   // widest field
  localparam int PosW      = 6;
  localparam int ModeW     = 2;
  localparam int ScaleW    = 32;
  localparam int QFrac     = 16;
  localparam int IntLimit  = 48;
  localparam int ExpBits   = 5;    // mode 1 exponent bits
  localparam int ExpBias   = 14;   // (4 + z) << (y + 14) is the Q16 value
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;
  localparam int HalfW     = RawW / 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW_BIT = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_MODE    = 2'd2,
    REG_SCALE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [ModeW-1:0] {
    MODE_POW_HALF = 2'd0,
    MODE_FLOAT7   = 2'd1,
    MODE_WRAP     = 2'd2,
    MODE_PLAIN    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [PosW-1:0]   field_low_bit;
    logic [PosW-1:0]   field_width;
    mode_t             decode_mode;
    logic [ScaleW-1:0] scale_factor;
  } cfg_t;

  typedef struct packed {
    logic            req_type;
    logic [RawW-1:0] raw_value;
  } req_t;

  typedef struct packed {
    logic [RawW-1:0] scaled_value;
    logic            saturated;
  } rsp_t;

  typedef struct packed {
    logic [RawW-1:0] q;      // Q48.16
    logic            ovf;
  } dec_t;

endpackage

// ===== rtl/rfd_track.sv =====
// ---------------------------------------------------------------------------
// Register field decoder history tracker
// Extracts the field, detects counter wraps and holds the sample history.
// ---------------------------------------------------------------------------
module rfd_track (
  input  logic                         clk,
  input  logic                         rst,
  input  rfd_pkg::cfg_t                cfg,
  input  logic                         load,
  input  rfd_pkg::req_t                req,
  output logic [rfd_pkg::FieldW-1:0]   field,
  output logic [rfd_pkg::CountBits-1:0] count
);
  import rfd_pkg::*;

  logic [RawW-1:0]      previous_raw;
  logic [CountBits-1:0] wrap_count;
  logic [RawW-1:0]      mask;
  logic [FieldW-1:0]    prev_field;
  logic                 tracked;
  logic                 wrapped;

  assign mask       = (RawW'(1) << cfg.field_width) - RawW'(1);
  assign field      = FieldW'((req.raw_value >> cfg.field_low_bit) & mask);
  assign prev_field = FieldW'((previous_raw >> cfg.field_low_bit) & mask);
  assign tracked    = !req.req_type;
  assign wrapped    = (cfg.decode_mode == MODE_WRAP) && (prev_field > field);
  // one-shot reads see no history
  assign count      = tracked ? wrap_count + CountBits'(wrapped) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw <= '0;
      wrap_count   <= '0;
    end else if (load && tracked) begin
      previous_raw <= req.raw_value;
      wrap_count   <= count;
    end
  end

`include "register_field_decoder_top_assert.svh"

  `RFD_ASSERT_NEXT(a_oneshot_keeps_history, load && req.req_type,
    $stable(previous_raw) && $stable(wrap_count))
  `RFD_ASSERT_NEXT(a_tracked_stores_raw, load && !req.req_type,
    previous_raw == $past(req.raw_value))
  `RFD_ASSERT_NEXT(a_count_steps_by_one, 1'b1,
    wrap_count == $past(wrap_count) || wrap_count == $past(wrap_count) + CountBits'(1))

endmodule

// ===== rtl/rfd_decode.sv =====
// ---------------------------------------------------------------------------
// Register field decoder value decode
// Turns a field and wrap count into Q48.16 per the selected mode.
// ---------------------------------------------------------------------------
module rfd_decode (
  input  rfd_pkg::cfg_t                 cfg,
  input  logic [rfd_pkg::FieldW-1:0]    field,
  input  logic [rfd_pkg::CountBits-1:0] count,
  output rfd_pkg::dec_t                 dec
);
  import rfd_pkg::*;

  localparam int ExtW  = CountBits + RawW;
  localparam int ManW  = FieldW - ExpBits + 1;
  localparam int WideW = 2 * RawW;

  logic [ExtW-1:0]    count_shift;
  logic               field_big;
  logic [ExpBits-1:0] flt_exp;
  logic [ManW-1:0]    flt_man;
  logic [PosW-1:0]    flt_shift;
  logic [WideW-1:0]   flt_wide;
  logic [RawW-1:0]    pow_val;

  // count lands above the field bits, so the sum is an OR
  assign count_shift = ExtW'(count) << cfg.field_width;
  assign field_big   = |field[FieldW-1:IntLimit];

  assign flt_exp   = field[ExpBits-1:0];
  assign flt_man   = ManW'(field[FieldW-1:ExpBits]) + ManW'(4);
  assign flt_shift = PosW'(flt_exp) + PosW'(ExpBias);
  assign flt_wide  = WideW'(flt_man) << flt_shift;

  assign pow_val = (field <= FieldW'(QFrac)) ?
                   RawW'(1) << (ExpBits'(QFrac) - field[ExpBits-1:0]) : '0;

  always_comb begin
    dec = '0;
    case (cfg.decode_mode)
      MODE_POW_HALF: begin
        dec.q = pow_val;
      end
      MODE_FLOAT7: begin
        dec.q   = flt_wide[RawW-1:0];
        dec.ovf = |flt_wide[WideW-1:RawW];
      end
      MODE_WRAP: begin
        dec.q   = {count_shift[IntLimit-1:0] | IntLimit'(field), QFrac'(0)};
        dec.ovf = (|count_shift[ExtW-1:IntLimit]) || field_big;
      end
      MODE_PLAIN: begin
        dec.q   = {field[IntLimit-1:0], QFrac'(0)};
        dec.ovf = field_big;
      end
      default: dec = '0;
    endcase
  end

endmodule

// ===== rtl/register_field_decoder_top.sv =====
// ---------------------------------------------------------------------------
// Register field decoder
// Extracts a bit field from a raw sample, decodes it and applies a scale.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  request | req_valid/req_stall  | req_data: req_type, raw_value
//  result  | rsp_valid/rsp_stall  | rsp_data: scaled_value, saturated
//  config  | cfg_we               | cfg_index, cfg_data
//
// Five-stage pipeline: input register, field/history, decode, two 32x32
// partial products, combine and saturate. One transaction per cycle while
// rsp_stall is low.
// Reset clears valids and history and sets config to its defaults; no clearing pass.
// A stalled result backs up stage by stage; empty stages still fill.
module register_field_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  rfd_pkg::req_t                 req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output rfd_pkg::rsp_t                 rsp_data,
  input  logic                          cfg_we,
  input  logic [rfd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rfd_pkg::CfgDataW-1:0]  cfg_data
);
  import rfd_pkg::*;

  cfg_t cfg;

  // stage registers
  logic                 v1, v2, v3, v4;
  req_t                 s1_req;
  logic [FieldW-1:0]    s2_field;
  logic [CountBits-1:0] s2_count;
  dec_t                 s3_dec;
  logic [RawW-1:0]      s4_lo, s4_hi;
  logic                 s4_ovf;

  logic                 rdy1, rdy2, rdy3, rdy4, rdy5;
  logic [FieldW-1:0]    field_next;
  logic [CountBits-1:0] count_next;
  dec_t                 dec_next;
  logic [RawW-1:0]      lo_next, hi_next;
  logic [RawW:0]        sum;
  rsp_t                 rsp_next;

  assign rdy5 = !rsp_valid || !rsp_stall;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign req_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_low_bit <= '0;
      cfg.field_width   <= PosW'(1);
      cfg.decode_mode   <= MODE_PLAIN;
      cfg.scale_factor  <= ScaleW'(32'h0001_0000);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOW_BIT: cfg.field_low_bit <= cfg_data[PosW-1:0];
        REG_WIDTH:   cfg.field_width   <= cfg_data[PosW-1:0];
        REG_MODE:    cfg.decode_mode   <= mode_t'(cfg_data[ModeW-1:0]);
        REG_SCALE:   cfg.scale_factor  <= cfg_data[ScaleW-1:0];
        default:     cfg.decode_mode   <= cfg.decode_mode;
      endcase
    end
  end

  rfd_track u_track (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .load  (v1 && rdy2),
    .req   (s1_req),
    .field (field_next),
    .count (count_next)
  );

  rfd_decode u_decode (
    .cfg   (cfg),
    .field (s2_field),
    .count (s2_count),
    .dec   (dec_next)
  );

  assign lo_next = RawW'(s3_dec.q[HalfW-1:0]) * RawW'(cfg.scale_factor);
  assign hi_next = RawW'(s3_dec.q[RawW-1:HalfW]) * RawW'(cfg.scale_factor);

  // full product >> 16, carry out of the sum means it passed 64 bits
  assign sum = {1'b0, s4_hi[IntLimit-1:0], QFrac'(0)} +
               {1'b0, QFrac'(0), s4_lo[RawW-1:QFrac]};

  always_comb begin
    if (s4_ovf) begin
      rsp_next.saturated = (cfg.scale_factor != '0);
    end else begin
      rsp_next.saturated = (|s4_hi[RawW-1:IntLimit]) || sum[RawW];
    end
    if (rsp_next.saturated) begin
      rsp_next.scaled_value = '1;
    end else if (s4_ovf) begin
      rsp_next.scaled_value = '0;
    end else begin
      rsp_next.scaled_value = sum[RawW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= req_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) rsp_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_req <= req_data;
    if (rdy2) begin
      s2_field <= field_next;
      s2_count <= count_next;
    end
    if (rdy3) s3_dec <= dec_next;
    if (rdy4) begin
      s4_lo  <= lo_next;
      s4_hi  <= hi_next;
      s4_ovf <= s3_dec.ovf;
    end
    if (rdy5) rsp_data <= rsp_next;
  end

`include "register_field_decoder_top_assert.svh"

  `RFD_ASSERT_IMPL(a_sat_is_all_ones, rsp_valid && rsp_data.saturated,
    rsp_data.scaled_value == '1)
  `RFD_ASSERT_IMPL(a_stall_needs_full_stage, req_stall, v1 && v2 && v3 && v4 && rsp_valid)
  `RFD_ASSERT_NEXT(a_ovf_result, v4 && rdy5 && s4_ovf && !cfg_we,
    rsp_valid && rsp_data.saturated == (cfg.scale_factor != '0))

endmodule

// ===== tb/register_field_decoder_top_test.sv =====
// ---------------------------------------------------------------------------
// Register field decoder testbench
// Drives raw register samples through the decoder under a series of field,
// mode and scale setups. Every accepted transaction is run through a local
// decode-and-scale predictor. Each result is checked field by field in order.
// A table of directed samples comes first, then random phases with idling.
// ---------------------------------------------------------------------------
module register_field_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfd_pkg::*;

  localparam logic REQ_TRACKED = 1'b0;
  localparam logic REQ_ONESHOT = 1'b1;
  localparam int   CycleLimit  = 400000;
  localparam int   NumPhases   = 16;
  localparam int   PhaseItems  = 115;
  localparam int   DrainCycles = 8;
  localparam logic [ScaleW-1:0] ScaleOne = 32'h0001_0000;

  typedef struct {
    bit   typed;
    rsp_t value;
  } typed_check_t;

  typedef struct {
    logic [PosW-1:0]   low;
    logic [PosW-1:0]   width;
    mode_t             mode;
    logic [ScaleW-1:0] scale;
    logic              kind;
    logic [RawW-1:0]   raw;
    bit                typed;
    logic [RawW-1:0]   xval;
    logic              xsat;
  } stim_row_t;

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_stall;
  req_t            req_data;
  logic            rsp_valid;
  logic            rsp_stall;
  rsp_t            rsp_data;
  logic            cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // predictor copy of config and history
  logic [PosW-1:0]      p_low;
  logic [PosW-1:0]      p_width;
  mode_t                p_mode;
  logic [ScaleW-1:0]    p_scale;
  logic [RawW-1:0]      p_prev_raw;
  logic [CountBits-1:0] p_wraps;

  rsp_t         pending_results[$];
  typed_check_t typed_results[$];
  stim_row_t    stim_rows[$];

  int  errors;
  int  cycles;
  int  samples_in;
  int  results_out;
  int  saturations;
  int  setups;
  int  gap_pct;
  int  stall_pct;
  bit  start_hold;

  logic [PosW-1:0]   cur_low;
  logic [PosW-1:0]   cur_width;
  mode_t             cur_mode;
  logic [ScaleW-1:0] cur_scale;

  register_field_decoder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL register_field_decoder_top");
      $finish;
    end
  end

  function automatic logic [RawW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [RawW-1:0] field_of(input logic [RawW-1:0] raw);
    logic [RawW-1:0] mask;
    mask = (64'd1 << p_width) - 64'd1;
    return (raw >> p_low) & mask;
  endfunction

  // decoded Q48.16 value in q; returns 1 when it does not fit
  function automatic logic decode_field(input logic [RawW-1:0] f,
                                        input logic [RawW-1:0] count,
                                        output logic [RawW-1:0] q);
    logic [RawW-1:0] v;
    logic [6:0]      sh;
    q = '0;
    v = f;
    case (p_mode)
      MODE_POW_HALF: begin
        if (f <= QFrac) q = 64'h1_0000 >> f[4:0];
        return 1'b0;
      end
      MODE_FLOAT7: begin
        v  = (f >> ExpBits) + 64'd4;
        sh = 7'(f[4:0]) + 7'(ExpBias);
        if ((v >> (7'd64 - sh)) != 0) return 1'b1;
        q = v << sh;
        return 1'b0;
      end
      MODE_WRAP: begin
        if (count != 0) begin
          if (p_width >= IntLimit) return 1'b1;
          if ((count >> (IntLimit - p_width)) != 0) return 1'b1;
          v = (count << p_width) + f;
        end
      end
      default: v = f;
    endcase
    if ((v >> IntLimit) != 0) return 1'b1;
    q = v << QFrac;
    return 1'b0;
  endfunction

  function automatic rsp_t decode_sample(input req_t r);
    logic [RawW-1:0] f, count, d, lo, hi, a, b, res;
    logic            sat;
    rsp_t            o;
    f     = field_of(r.raw_value);
    count = '0;
    if (r.req_type == REQ_TRACKED) begin
      if (p_mode == MODE_WRAP && field_of(p_prev_raw) > f) p_wraps = p_wraps + 1'b1;
      count      = 64'(p_wraps);
      p_prev_raw = r.raw_value;
    end
    if (decode_field(f, count, d)) begin
      sat = (p_scale != 0);
      res = sat ? '1 : '0;
    end else begin
      lo  = {32'd0, d[31:0]} * {32'd0, p_scale};
      hi  = {32'd0, d[63:32]} * {32'd0, p_scale};
      sat = 1'b0;
      res = '0;
      if ((hi >> IntLimit) != 0) begin
        sat = 1'b1;
      end else begin
        a   = hi << QFrac;
        b   = lo >> QFrac;
        res = a + b;
        if (res < a) sat = 1'b1;
      end
      if (sat) res = '1;
    end
    o.scaled_value = res;
    o.saturated    = sat;
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t         want;
    typed_check_t t;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LOW_BIT: p_low   = cfg_data[PosW-1:0];
          REG_WIDTH:   p_width = cfg_data[PosW-1:0];
          REG_MODE:    p_mode  = mode_t'(cfg_data[ModeW-1:0]);
          REG_SCALE:   p_scale = cfg_data[ScaleW-1:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        want = decode_sample(req_data);
        if (typed_results.size() != 0) begin
          t = typed_results.pop_front();
          if (t.typed) want = t.value;
        end
        pending_results.push_back(want);
        samples_in++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing pending: %h", rsp_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_data.scaled_value !== want.scaled_value) begin
            $error("scaled_value mismatch: expected %h, actual %h",
                   want.scaled_value, rsp_data.scaled_value);
            errors++;
          end
          if (rsp_data.saturated !== want.saturated) begin
            $error("saturated mismatch: expected %b, actual %b",
                   want.saturated, rsp_data.saturated);
            errors++;
          end
          if (rsp_data.saturated === 1'b1) saturations++;
          results_out++;
        end
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (start_hold) begin
        start_hold = 1'b0;
        hold_left  = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic add_row(input logic [PosW-1:0] low, input logic [PosW-1:0] width,
                         input mode_t mode, input logic [ScaleW-1:0] scale,
                         input logic kind, input logic [RawW-1:0] raw,
                         input bit typed, input logic [RawW-1:0] xval,
                         input logic xsat);
    stim_row_t r;
    r.low   = low;
    r.width = width;
    r.mode  = mode;
    r.scale = scale;
    r.kind  = kind;
    r.raw   = raw;
    r.typed = typed;
    r.xval  = xval;
    r.xsat  = xsat;
    stim_rows.push_back(r);
  endtask

  // waits for the pipe to drain, then rewrites all four registers
  task automatic program_setup(input logic [PosW-1:0] low, input logic [PosW-1:0] width,
                               input mode_t mode, input logic [ScaleW-1:0] scale);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOW_BIT;
    cfg_data  <= 32'(low);
    @(negedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data  <= 32'(width);
    @(negedge clk);
    cfg_index <= REG_MODE;
    cfg_data  <= 32'(mode);
    @(negedge clk);
    cfg_index <= REG_SCALE;
    cfg_data  <= scale;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_low   = low;
    cur_width = width;
    cur_mode  = mode;
    cur_scale = scale;
    setups++;
  endtask

  // called and returns at a falling edge; holds the payload until accepted
  task automatic put_req(input logic kind, input logic [RawW-1:0] raw,
                         input bit typed, input rsp_t value);
    typed_check_t t;
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    t.typed = typed;
    t.value = value;
    typed_results.push_back(t);
    req_valid          <= 1'b1;
    req_data.req_type  <= kind;
    req_data.raw_value <= raw;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t         r;
    rsp_t              v;
    logic [PosW-1:0]   low, width;
    mode_t             mode;
    logic [ScaleW-1:0] scale;
    logic [RawW-1:0]   mask, fv, ctr, raw;
    logic              kind;
    int                idle_kind;

    rst        = 1'b1;
    req_valid  = 1'b0;
    req_data   = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    errors     = 0;
    cycles     = 0;
    samples_in = 0;
    results_out = 0;
    saturations = 0;
    setups     = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    start_hold = 1'b0;
    p_low      = '0;
    p_width    = 6'd1;
    p_mode     = MODE_PLAIN;
    p_scale    = ScaleOne;
    p_prev_raw = '0;
    p_wraps    = '0;
    cur_low    = '0;
    cur_width  = 6'd1;
    cur_mode   = MODE_PLAIN;
    cur_scale  = ScaleOne;
    ctr        = '0;

    // directed samples: setup, kind, raw, then typed expectation if obvious
    add_row(0, 1, MODE_PLAIN, ScaleOne, REQ_TRACKED, 64'd1, 1, 64'h1_0000, 0);
    add_row(0, 1, MODE_PLAIN, ScaleOne, REQ_ONESHOT, '1, 1, 64'h1_0000, 0);
    add_row(0, 1, MODE_PLAIN, ScaleOne, REQ_TRACKED, 64'd0, 1, 64'd0, 0);
    add_row(0, 63, MODE_PLAIN, ScaleOne, REQ_TRACKED, '1, 1, '1, 1);
    add_row(0, 63, MODE_PLAIN, ScaleOne, REQ_ONESHOT, 64'h0000_FFFF_FFFF_FFFF,
            1, 64'hFFFF_FFFF_FFFF_0000, 0);
    add_row(0, 63, MODE_PLAIN, ScaleOne, REQ_TRACKED, 64'h0001_0000_0000_0000, 1, '1, 1);
    add_row(0, 63, MODE_PLAIN, '1, REQ_TRACKED, 64'd1, 1, 64'h0000_0000_FFFF_FFFF, 0);
    add_row(0, 63, MODE_PLAIN, '1, REQ_TRACKED, 64'h1_0000, 0, '0, 0);
    add_row(0, 63, MODE_PLAIN, '1, REQ_TRACKED, 64'h0000_FFFF_FFFF_FFFF, 0, '0, 0);
    // overflowing decode with a zero scale gives zero, not saturation
    add_row(0, 63, MODE_PLAIN, 32'd0, REQ_TRACKED, '1, 1, 64'd0, 0);
    // field running past bit 63 sees zeros above the word
    add_row(63, 63, MODE_PLAIN, ScaleOne, REQ_TRACKED, '1, 1, 64'h1_0000, 0);
    add_row(63, 63, MODE_PLAIN, ScaleOne, REQ_ONESHOT, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'd0, 0);
    add_row(60, 8, MODE_PLAIN, ScaleOne, REQ_TRACKED, 64'hF000_0000_0000_0000,
            1, 64'hF_0000, 0);
    add_row(0, 0, MODE_PLAIN, ScaleOne, REQ_TRACKED, '1, 1, 64'd0, 0);
    add_row(0, 6, MODE_POW_HALF, ScaleOne, REQ_TRACKED, 64'd0, 1, 64'h1_0000, 0);
    add_row(0, 6, MODE_POW_HALF, ScaleOne, REQ_TRACKED, 64'd16, 1, 64'd1, 0);
    add_row(0, 6, MODE_POW_HALF, ScaleOne, REQ_TRACKED, 64'd17, 1, 64'd0, 0);
    add_row(0, 6, MODE_POW_HALF, ScaleOne, REQ_ONESHOT, 64'd63, 1, 64'd0, 0);
    add_row(0, 7, MODE_FLOAT7, ScaleOne, REQ_TRACKED, 64'd0, 1, 64'h1_0000, 0);
    add_row(0, 7, MODE_FLOAT7, ScaleOne, REQ_TRACKED, 64'h7F, 0, '0, 0);
    add_row(0, 12, MODE_FLOAT7, ScaleOne, REQ_TRACKED, 64'hFFF, 0, '0, 0);
    add_row(0, 63, MODE_FLOAT7, ScaleOne, REQ_TRACKED, '1, 1, '1, 1);
    // wrap counting: 5 then 3 wraps once; the one-shot read has no history
    add_row(0, 4, MODE_WRAP, ScaleOne, REQ_TRACKED, 64'd5, 0, '0, 0);
    add_row(0, 4, MODE_WRAP, ScaleOne, REQ_TRACKED, 64'd3, 0, '0, 0);
    add_row(0, 4, MODE_WRAP, ScaleOne, REQ_ONESHOT, 64'd2, 1, 64'h2_0000, 0);
    add_row(0, 4, MODE_WRAP, ScaleOne, REQ_TRACKED, 64'd9, 0, '0, 0);
    // nonzero count with a 48-bit field cannot fit
    add_row(0, 48, MODE_WRAP, ScaleOne, REQ_TRACKED, 64'd0, 1, '1, 1);

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      if (r.low != cur_low || r.width != cur_width || r.mode != cur_mode ||
          r.scale != cur_scale)
        program_setup(r.low, r.width, r.mode, r.scale);
      v.scaled_value = r.xval;
      v.saturated    = r.xsat;
      put_req(r.kind, r.raw, r.typed, v);
    end

    for (int p = 0; p < NumPhases; p++) begin
      mode = mode_t'(p % 4);
      case ($urandom_range(0, 7))
        0: begin low = 0; width = 63; end
        1: begin low = 63; width = 6'($urandom_range(0, 63)); end
        2: begin low = 6'($urandom_range(0, 63)); width = 0; end
        3: begin low = 6'($urandom_range(0, 63)); width = 6'($urandom_range(1, 63)); end
        default: begin
          case (mode)
            MODE_POW_HALF: width = 6'($urandom_range(1, 6));
            MODE_FLOAT7:   width = 6'($urandom_range(5, 12));
            MODE_WRAP:     width = 6'($urandom_range(3, 20));
            default:       width = 6'($urandom_range(1, 63));
          endcase
          low = 6'($urandom_range(0, 64 - int'(width)));
        end
      endcase
      case ($urandom_range(0, 7))
        0: scale = 32'd0;
        1: scale = '1;
        2: scale = 32'($urandom_range(0, 32'hFFFF));
        3: scale = $urandom;
        default: scale = ScaleOne;
      endcase
      program_setup(low, width, mode, scale);

      idle_kind = p / 4;
      gap_pct   = (idle_kind == 1) ? 45 : (idle_kind == 3) ? 37 : 0;
      stall_pct = (idle_kind == 2) ? 45 : (idle_kind == 3) ? 37 : 0;
      mask = (64'd1 << width) - 64'd1;

      for (int i = 0; i < PhaseItems; i++) begin
        kind = ($urandom_range(0, 9) == 0) ? REQ_ONESHOT : REQ_TRACKED;
        case (mode)
          MODE_WRAP: begin
            // mostly a climbing counter that wraps now and then
            if ($urandom_range(0, 99) < 85) begin
              ctr = (ctr + (rand64() & (mask >> 2))) & mask;
              fv  = ctr;
            end else begin
              fv = rand64();
            end
          end
          MODE_POW_HALF: fv = ($urandom_range(0, 9) < 6) ? 64'($urandom_range(0, 20))
                                                         : rand64();
          default: begin
            case ($urandom_range(0, 9))
              0: fv = '0;
              1: fv = '1;
              default: fv = rand64();
            endcase
          end
        endcase
        raw = rand64();
        if ($urandom_range(0, 9) != 0)
          raw = (raw & ~(mask << low)) | ((fv & mask) << low);
        if (p == 5 && i == 20) start_hold = 1'b1;
        if (p == 9 && i == 60) begin
          while (pending_results.size() != 0) begin
            req_valid <= 1'b0;
            @(negedge clk);
          end
        end
        v = '0;
        put_req(kind, raw, 0, v);
      end
    end

    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Covered %0d samples, %0d results (%0d saturated) over %0d register setups",
             samples_in, results_out, saturations, setups);
    $display("All four decode modes ran with and without sender gaps and result stalls");
    if (errors == 0) begin
      $display("PASS register_field_decoder_top");
    end else begin
      $display("FAIL register_field_decoder_top");
    end
    $finish;
  end

endmodule
